### rtl/mqlb_pkg.sv
// Shared types, constants and helper functions of the multi-queue linked buffer.
package mqlb_pkg;

  // Sizes of the shared store and the field widths.
  localparam int ENTRIES    = 64;
  localparam int QUEUES     = 4;
  localparam int DATA_WIDTH = 32;
  localparam int QSEL_W     = 2;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int PTR_W      = $clog2(ENTRIES + 1);

  // Command queue between front and back; the depth must be a power of two.
  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // A link value of ENTRIES marks the end of a chain.
  localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRIES);

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } back_state_t;

  // One input item as it arrives on the command port.
  typedef struct packed {
    func_t                  func;
    logic [QSEL_W-1:0]      queue_sel;
    logic [DATA_WIDTH-1:0]  push_value;
  } cmd_t;

  // One result item.
  typedef struct packed {
    status_t                status;
    logic [DATA_WIDTH-1:0]  pop_value;
  } rsp_t;

  // A classified item as it travels from front to back.
  typedef struct packed {
    func_t                  func;
    logic [QSEL_W-1:0]      queue_sel;
    logic                   queue_ok;
    logic [DATA_WIDTH-1:0]  value;
  } op_t;

  // Link held by an entry that has not been written since reset.
  function automatic logic [PTR_W-1:0] reset_link(input logic [IDX_W-1:0] idx);
    logic [PTR_W-1:0] nxt;
    nxt = PTR_W'(idx) + PTR_W'(1);
    if (idx == IDX_W'(ENTRIES - 1)) begin
      nxt = NIL;
    end
    return nxt;
  endfunction

endpackage

### rtl/mqlb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mqlb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read in the same cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/mqlb_front.sv
// Front end: accepts command items, classifies them and queues them for the back end.
module mqlb_front
  import mqlb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic op_valid,
  output op_t  op,
  input  logic op_take
);

  op_t               slots [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr;
  logic [FPTR_W-1:0] rd_ptr;
  logic [FCNT_W-1:0] count;
  logic              accept;
  logic              take;
  op_t               classified;

  assign busy     = (count == FCNT_W'(FIFO_DEPTH));
  assign accept   = start && !busy;
  assign op_valid = (count != '0);
  assign take     = op_take && op_valid;
  assign op       = slots[rd_ptr];

  // Classify the item: mark whether the addressed queue exists.
  always_comb begin
    classified.func      = cmd.func;
    classified.queue_sel = cmd.queue_sel;
    classified.queue_ok  = (int'(cmd.queue_sel) < QUEUES);
    classified.value     = cmd.push_value;
  end

  // Queue storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= classified;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + FPTR_W'(1);
      end
      if (take) begin
        rd_ptr <= rd_ptr + FPTR_W'(1);
      end
      if (accept && !take) begin
        count <= count + FCNT_W'(1);
      end else if (take && !accept) begin
        count <= count - FCNT_W'(1);
      end
    end
  end

endmodule

### rtl/mqlb_back.sv
// Back end: carries out pushes and pops on the linked entry store and the free list.
module mqlb_back
  import mqlb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic op_valid,
  input  op_t  op,
  output logic op_take,
  output logic done,
  output rsp_t result
);

  back_state_t            state;
  back_state_t            state_next;
  op_t                    cur;
  logic [IDX_W-1:0]       rd_addr;
  logic                   rd_vld;
  logic [ENTRIES-1:0]     link_vld;
  logic [PTR_W-1:0]       queue_head [QUEUES];
  logic [PTR_W-1:0]       queue_tail [QUEUES];
  logic [PTR_W-1:0]       free_head;

  logic [IDX_W-1:0]       issue_addr;
  logic [PTR_W-1:0]       link_rdata;
  logic [PTR_W-1:0]       link_val;
  logic [DATA_WIDTH-1:0]  data_rdata;

  logic                   link_we;
  logic [IDX_W-1:0]       link_waddr;
  logic [PTR_W-1:0]       link_wdata;
  logic                   data_we;
  logic [IDX_W-1:0]       data_waddr;
  logic                   head_we;
  logic [PTR_W-1:0]       head_next;
  logic                   tail_we;
  logic [PTR_W-1:0]       free_head_next;
  rsp_t                   result_next;
  logic [PTR_W-1:0]       cur_head;
  logic [PTR_W-1:0]       cur_tail;

  assign cur_head = queue_head[cur.queue_sel];
  assign cur_tail = queue_tail[cur.queue_sel];

  // A push reads the link of the free-list head, a pop the link of the queue head.
  always_comb begin
    if (op.func == FUNC_PUSH) begin
      issue_addr = free_head[IDX_W-1:0];
    end else begin
      issue_addr = queue_head[op.queue_sel][IDX_W-1:0];
    end
  end

  // Entries never written since reset still hold their reset link.
  assign link_val = rd_vld ? link_rdata : reset_link(rd_addr);

  mqlb_ram #(
    .WIDTH (PTR_W),
    .DEPTH (ENTRIES)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (issue_addr),
    .rdata (link_rdata)
  );

  mqlb_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (ENTRIES)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (cur.value),
    .raddr (issue_addr),
    .rdata (data_rdata)
  );

  // Sequencer: issue reads in idle, update links and pointers in the execute cycle.
  always_comb begin
    state_next         = state;
    op_take            = 1'b0;
    link_we            = 1'b0;
    link_waddr         = cur_tail[IDX_W-1:0];
    link_wdata         = free_head;
    data_we            = 1'b0;
    data_waddr         = free_head[IDX_W-1:0];
    head_we            = 1'b0;
    head_next          = free_head;
    tail_we            = 1'b0;
    free_head_next     = free_head;
    result_next.status = ST_OK;
    result_next.pop_value = '0;
    case (state)
      BK_IDLE: begin
        if (op_valid) begin
          op_take    = 1'b1;
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        state_next = BK_IDLE;
        if (cur.func == FUNC_PUSH) begin
          if (!cur.queue_ok || free_head >= NIL) begin
            result_next.status = ST_FULL;
          end else begin
            // Take the free-list head and append it behind the tail.
            free_head_next = link_val;
            data_we        = 1'b1;
            tail_we        = 1'b1;
            if (cur_head >= NIL) begin
              head_we   = 1'b1;
              head_next = free_head;
            end else if (cur_tail < NIL) begin
              link_we    = 1'b1;
              link_waddr = cur_tail[IDX_W-1:0];
              link_wdata = free_head;
            end
          end
        end else begin
          if (!cur.queue_ok || cur_head >= NIL) begin
            result_next.status = ST_EMPTY;
          end else begin
            // The tail's own link is never written on append, so a pop of the
            // last entry ends the chain here instead of following it.
            head_we   = 1'b1;
            head_next = (cur_head == cur_tail) ? NIL : link_val;
            link_we    = 1'b1;
            link_waddr = cur_head[IDX_W-1:0];
            link_wdata = free_head;
            free_head_next = cur_head;
            result_next.pop_value = data_rdata;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Control state, queue pointers and link valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      done      <= 1'b0;
      link_vld  <= '0;
      free_head <= '0;
      for (int i = 0; i < QUEUES; i++) begin
        queue_head[i] <= NIL;
        queue_tail[i] <= NIL;
      end
    end else begin
      state     <= state_next;
      done      <= (state == BK_EXEC);
      free_head <= free_head_next;
      if (link_we) begin
        link_vld[link_waddr] <= 1'b1;
      end
      if (head_we) begin
        queue_head[cur.queue_sel] <= head_next;
      end
      if (tail_we) begin
        queue_tail[cur.queue_sel] <= free_head;
      end
    end
  end

  // Current item, read tracking and result payload.
  always_ff @(posedge clk) begin
    if (op_take) begin
      cur     <= op;
      rd_addr <= issue_addr;
      rd_vld  <= link_vld[issue_addr];
    end
    if (state == BK_EXEC) begin
      result <= result_next;
    end
  end

endmodule

### rtl/multi_queue_linked_buffer.sv
// Top level of the multi-queue linked buffer: front end, command queue and back end.
//
//   channel  | handshake          | payload | direction
//   ---------+--------------------+---------+----------
//   command  | start / busy       | cmd     | in
//   result   | done (strobe)      | result  | out
//
// The back end takes each item through idle, which reads the link and data
// memories at the free-list or queue head, and execute, which writes the updated link.
// The result appears in the cycle after execute, for one cycle, marked by done.
// A two-entry command queue lets up to two items wait while one is at work.
// Synchronous reset clears all pointers; no clearing pass is needed.
// The receiver cannot stall; busy rises only when the command queue is full.
module multi_queue_linked_buffer
  import mqlb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output rsp_t result
);

  logic op_valid;
  logic op_take;
  op_t  op;

  mqlb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take)
  );

  mqlb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take),
    .done     (done),
    .result   (result)
  );

`ifndef NO_ASSERTIONS
  // The back end returns to idle after each execute state, so results never come back to back.
  a_no_back_to_back: assert property (@(posedge clk) done |=> !done)
    else $error("results delivered in consecutive cycles");

  // A rejected item never carries a value.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> (result.pop_value == '0))
    else $error("rejected item carries a nonzero value");

  // Reset leaves no result pending and the command queue empty.
  a_reset_clear: assert property (@(posedge clk) rst |=> (!done && !busy))
    else $error("result or busy after reset");
`endif

endmodule
